// ----- rtl/xcfr_pkg.sv -----
// Package for the XOR-checked frame receiver.
// Holds the parser state type, the sync and framing constants and parameter defaults.
// No dependencies.
package xcfr_pkg;

  localparam int MaxPayloadDefault   = 64;
  localparam int CounterWidthDefault = 16;

  localparam logic [7:0] SyncFirst  = 8'hAA;
  localparam logic [7:0] SyncSecond = 8'h55;
  localparam int         IdBytes    = 4;

  typedef enum logic [2:0] {
    StHunt1 = 3'd0,
    StHunt2 = 3'd1,
    StLenLo = 3'd2,
    StLenHi = 3'd3,
    StBody  = 3'd4,
    StCheck = 3'd5,
    StEmit  = 3'd6
  } state_e;

endpackage

// ----- rtl/xcfr_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Used for the payload buffer. No dependencies.
module xcfr_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/xcfr_parser.sv -----
// Frame parser: sync hunt, length check, body capture with running XOR, error counters.
// Writes payload bytes into the buffer RAM. Depends on xcfr_pkg.
module xcfr_parser #(
  parameter int MaxPayload   = xcfr_pkg::MaxPayloadDefault,
  parameter int CounterWidth = xcfr_pkg::CounterWidthDefault,
  parameter int AddrW        = (MaxPayload > 1) ? $clog2(MaxPayload) : 1,
  parameter int PlenW        = $clog2(MaxPayload + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic [7:0]              in_byte_i,
  output logic                    in_ready_o,
  input  logic                    emit_done_i,
  output logic                    emit_start_o,
  output logic [PlenW-1:0]        plen_o,
  output logic [31:0]             can_id_o,
  output logic [CounterWidth-1:0] cerr_o,
  output logic [CounterWidth-1:0] lerr_o,
  output logic                    we_o,
  output logic [AddrW-1:0]        waddr_o,
  output logic [7:0]              wdata_o
);

  localparam int BodyMin = xcfr_pkg::IdBytes + 1;
  localparam int BodyMax = xcfr_pkg::IdBytes + MaxPayload;
  localparam int LenW    = $clog2(BodyMax + 1);

  xcfr_pkg::state_e state_q, state_d;

  logic [7:0]              len_lo_q, len_lo_d;
  logic [LenW-1:0]         flen_q, flen_d;
  logic [LenW-1:0]         bc_q, bc_d;
  logic [7:0]              xor_q, xor_d;
  logic [31:0]             id_q, id_d;
  logic [CounterWidth-1:0] cerr_q, cerr_d;
  logic [CounterWidth-1:0] lerr_q, lerr_d;

  logic            accept;
  logic [15:0]     len_full;
  logic            len_ok;
  logic [LenW-1:0] bc_next;

  assign in_ready_o = (state_q != xcfr_pkg::StEmit);
  assign accept     = in_valid_i && in_ready_o;
  assign len_full   = {in_byte_i, len_lo_q};
  assign len_ok     = (len_full >= 16'(BodyMin)) && (len_full <= 16'(BodyMax));
  assign bc_next    = bc_q + LenW'(1);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      xcfr_pkg::StHunt2: begin
        if (accept) begin
          state_d = (in_byte_i == xcfr_pkg::SyncSecond) ? xcfr_pkg::StLenLo : xcfr_pkg::StHunt1;
        end
      end
      xcfr_pkg::StLenLo: begin
        if (accept) begin
          state_d = xcfr_pkg::StLenHi;
        end
      end
      xcfr_pkg::StLenHi: begin
        if (accept) begin
          state_d = len_ok ? xcfr_pkg::StBody : xcfr_pkg::StHunt1;
        end
      end
      xcfr_pkg::StBody: begin
        if (accept && (bc_next >= flen_q)) begin
          state_d = xcfr_pkg::StCheck;
        end
      end
      xcfr_pkg::StCheck: begin
        if (accept) begin
          state_d = (in_byte_i == xor_q) ? xcfr_pkg::StEmit : xcfr_pkg::StHunt1;
        end
      end
      xcfr_pkg::StEmit: begin
        if (emit_done_i) begin
          state_d = xcfr_pkg::StHunt1;
        end
      end
      default: begin
        if (accept) begin
          state_d = (in_byte_i == xcfr_pkg::SyncFirst) ? xcfr_pkg::StHunt2 : xcfr_pkg::StHunt1;
        end
      end
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    len_lo_d     = len_lo_q;
    flen_d       = flen_q;
    bc_d         = bc_q;
    xor_d        = xor_q;
    id_d         = id_q;
    cerr_d       = cerr_q;
    lerr_d       = lerr_q;
    we_o         = 1'b0;
    waddr_o      = AddrW'(bc_q - LenW'(xcfr_pkg::IdBytes));
    wdata_o      = in_byte_i;
    emit_start_o = 1'b0;
    case (state_q)
      xcfr_pkg::StLenLo: begin
        if (accept) begin
          len_lo_d = in_byte_i;
        end
      end
      xcfr_pkg::StLenHi: begin
        if (accept) begin
          if (len_ok) begin
            flen_d = LenW'(len_full);
            bc_d   = '0;
            xor_d  = '0;
          end else if (lerr_q != '1) begin
            lerr_d = lerr_q + CounterWidth'(1);
          end
        end
      end
      xcfr_pkg::StBody: begin
        if (accept) begin
          bc_d  = bc_next;
          xor_d = xor_q ^ in_byte_i;
          if (bc_q < LenW'(xcfr_pkg::IdBytes)) begin
            id_d[{bc_q[1:0], 3'b000} +: 8] = in_byte_i;
          end else begin
            we_o = 1'b1;
          end
        end
      end
      xcfr_pkg::StCheck: begin
        if (accept) begin
          if (in_byte_i == xor_q) begin
            emit_start_o = 1'b1;
          end else if (cerr_q != '1) begin
            cerr_d = cerr_q + CounterWidth'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= xcfr_pkg::StHunt1;
      len_lo_q <= '0;
      flen_q   <= '0;
      bc_q     <= '0;
      xor_q    <= '0;
      id_q     <= '0;
      cerr_q   <= '0;
      lerr_q   <= '0;
    end else begin
      state_q  <= state_d;
      len_lo_q <= len_lo_d;
      flen_q   <= flen_d;
      bc_q     <= bc_d;
      xor_q    <= xor_d;
      id_q     <= id_d;
      cerr_q   <= cerr_d;
      lerr_q   <= lerr_d;
    end
  end

  assign plen_o   = PlenW'(flen_q - LenW'(xcfr_pkg::IdBytes));
  assign can_id_o = id_q;
  assign cerr_o   = cerr_q;
  assign lerr_o   = lerr_q;

endmodule

// ----- rtl/xcfr_emitter.sv -----
// Payload emitter: walks the buffer RAM, one payload word per cycle unless stalled.
// The RAM's registered read data serves as the output register. Depends on xcfr_pkg.
module xcfr_emitter #(
  parameter int MaxPayload = xcfr_pkg::MaxPayloadDefault,
  parameter int AddrW      = (MaxPayload > 1) ? $clog2(MaxPayload) : 1,
  parameter int PlenW      = $clog2(MaxPayload + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [PlenW-1:0] plen_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic             out_last_o,
  output logic [AddrW-1:0] idx_o,
  output logic             re_o,
  output logic [AddrW-1:0] raddr_o,
  output logic             done_o
);

  logic             busy_q, busy_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic             advance;

  assign out_valid_o = busy_q;
  assign out_last_o  = (PlenW'(idx_q) + PlenW'(1)) == plen_i;
  assign advance     = busy_q && out_ready_i && !out_last_o;
  assign done_o      = busy_q && out_ready_i && out_last_o;

  // A new read is issued on the same edge that the current word is taken.
  always_comb begin
    re_o    = start_i || advance;
    raddr_o = start_i ? '0 : idx_q + AddrW'(1);
    idx_d   = re_o ? raddr_o : idx_q;
    busy_d  = start_i ? 1'b1 : (done_o ? 1'b0 : busy_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  assign idx_o = idx_q;

endmodule

// ----- rtl/xor_checked_frame_receiver.sv -----
// Latency: the first payload word of a verified frame is valid the cycle after its checksum
// byte is accepted; further words follow one per cycle while the sink is ready.
// Throughput: one received byte per cycle during parsing; input is held off while a verified
// payload is being delivered, until its last word has been taken.
// Reset: asynchronous, active low; returns to sync hunting and clears both error counters.
// The payload buffer is not cleared; it is always written before it is read.
module xor_checked_frame_receiver #(
  parameter int MaxPayload   = xcfr_pkg::MaxPayloadDefault,
  parameter int CounterWidth = xcfr_pkg::CounterWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Receive side: one byte from the serial link per word.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // Result side: one payload byte of a verified frame per word.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] can_id, [39:32] data_byte, [45:40] byte_index, [52:46] payload_length,
  // [68:53] checksum_error_count, [84:69] length_error_count, [87:85] zero
  output logic [87:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int AddrW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
  localparam int PlenW = $clog2(MaxPayload + 1);

  logic                    emit_start;
  logic                    emit_done;
  logic [PlenW-1:0]        plen;
  logic [31:0]             can_id;
  logic [CounterWidth-1:0] cerr;
  logic [CounterWidth-1:0] lerr;
  logic                    we;
  logic [AddrW-1:0]        waddr;
  logic [7:0]              wdata;
  logic                    re;
  logic [AddrW-1:0]        raddr;
  logic [7:0]              rdata;
  logic [AddrW-1:0]        idx;

  // The parser owns the frame state and the write port of the buffer.
  xcfr_parser #(
    .MaxPayload  (MaxPayload),
    .CounterWidth(CounterWidth),
    .AddrW       (AddrW),
    .PlenW       (PlenW)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_byte_i   (s_axis_tdata),
    .in_ready_o  (s_axis_tready),
    .emit_done_i (emit_done),
    .emit_start_o(emit_start),
    .plen_o      (plen),
    .can_id_o    (can_id),
    .cerr_o      (cerr),
    .lerr_o      (lerr),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata)
  );

  // Payload buffer. The identifier bytes are kept in the parser, so only the payload lands here.
  xcfr_ram #(
    .Width(8),
    .Depth(MaxPayload),
    .AddrW(AddrW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // The emitter reads the buffer back in order. Reads and writes never overlap, because the
  // parser holds off new bytes until the last payload word has been taken.
  xcfr_emitter #(
    .MaxPayload(MaxPayload),
    .AddrW     (AddrW),
    .PlenW     (PlenW)
  ) u_emitter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (emit_start),
    .plen_i     (plen),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_last_o (m_axis_tlast),
    .idx_o      (idx),
    .re_o       (re),
    .raddr_o    (raddr),
    .done_o     (emit_done)
  );

  // Counters cannot move during delivery, so they are read straight from the parser.
  assign m_axis_tdata = {3'b000, 16'(lerr), 16'(cerr), 7'(plen), 6'(idx), rdata, can_id};

endmodule

// ----- rtl/xcfr_checker.sv -----
// Port-level checker for the XOR-checked frame receiver, bound to the top level.
// Depends only on the top level's ports.
module xcfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // A stalled result word holds its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result word changed");

  // Receive side is held off while a payload is being delivered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input accepted during payload delivery");

  // After the last word is taken the result side goes quiet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("result word after end of frame");

  // Inside a frame the byte index steps by one per taken word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && (m_axis_tdata[45:40] == 6'($past(m_axis_tdata[45:40]) + 6'd1)))
    else $error("byte index did not advance");

endmodule

bind xor_checked_frame_receiver xcfr_checker u_checker (.*);

// ----- dv/tb_xor_checked_frame_receiver.sv -----
// Self-checking testbench for xor_checked_frame_receiver: drives received bytes on the
// stream input and checks every payload word against a built-in frame parser.
// Depends on xcfr_pkg and the receiver RTL.
`timescale 1ns / 1ps

module tb_xor_checked_frame_receiver;

  localparam int MaxPayload = xcfr_pkg::MaxPayloadDefault;
  localparam int CntWidth   = xcfr_pkg::CounterWidthDefault;
  localparam int BodyMin    = xcfr_pkg::IdBytes + 1;
  localparam int BodyMax    = xcfr_pkg::IdBytes + MaxPayload;

  localparam int RandomItems = 20;
  localparam int LongHold    = 300;
  localparam int DrainCycles = 2 * MaxPayload + 20;
  localparam int QuietLimit  = 2000;

  typedef struct {
    logic [31:0] can_id;
    logic [7:0]  data_byte;
    logic [5:0]  byte_index;
    logic [6:0]  payload_length;
    logic        last;
    logic [15:0] checksum_errors;
    logic [15:0] length_errors;
  } payload_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [31:0] can_id, [39:32] data_byte, [45:40] byte_index, [52:46] payload_length,
  // [68:53] checksum_error_count, [84:69] length_error_count, [87:85] zero
  logic [87:0] m_axis_tdata;
  logic        m_axis_tlast;

  xor_checked_frame_receiver #(
    .MaxPayload  (MaxPayload),
    .CounterWidth(CntWidth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Parser copy kept by the testbench.
  xcfr_pkg::state_e      rx_phase = xcfr_pkg::StHunt1;
  logic [15:0]           rx_len = '0;
  logic [6:0]            rx_count = '0;
  logic [7:0]            rx_xor = '0;
  logic [7:0]            body_mem [BodyMax];
  logic [CntWidth-1:0]   cks_errs = '0;
  logic [CntWidth-1:0]   len_errs = '0;

  payload_word_t pending_payload_q [$];

  int  errors_seen = 0;
  int  bytes_sent = 0;
  int  quiet_cycles = 0;
  int  holds_asked = 0;
  int  holds_done = 0;
  bit  idle_on = 1'b1;

  function automatic logic [CntWidth-1:0] bump(input logic [CntWidth-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // Advance the parser copy by one accepted byte and queue any payload words it releases.
  task automatic parse_rx_byte(input logic [7:0] b);
    payload_word_t w;
    logic [15:0]   fl;
    logic [15:0]   plen;
    case (rx_phase)
      xcfr_pkg::StHunt2: begin
        // Only 0x55 goes on; a repeated 0xAA does not restart the sync pair.
        rx_phase = (b == xcfr_pkg::SyncSecond) ? xcfr_pkg::StLenLo : xcfr_pkg::StHunt1;
      end
      xcfr_pkg::StLenLo: begin
        rx_len   = {8'h00, b};
        rx_phase = xcfr_pkg::StLenHi;
      end
      xcfr_pkg::StLenHi: begin
        fl     = {b, rx_len[7:0]};
        rx_len = fl;
        if (fl < BodyMin || fl > BodyMax) begin
          len_errs = bump(len_errs);
          rx_phase = xcfr_pkg::StHunt1;
        end else begin
          rx_count = '0;
          rx_xor   = '0;
          rx_phase = xcfr_pkg::StBody;
        end
      end
      xcfr_pkg::StBody: begin
        if (rx_count < BodyMax) body_mem[rx_count] = b;
        rx_count = rx_count + 1'b1;
        rx_xor   = rx_xor ^ b;
        if (rx_count >= rx_len) rx_phase = xcfr_pkg::StCheck;
      end
      xcfr_pkg::StCheck: begin
        rx_phase = xcfr_pkg::StHunt1;
        if (b != rx_xor) begin
          cks_errs = bump(cks_errs);
        end else begin
          plen = rx_len - 16'(xcfr_pkg::IdBytes);
          for (int i = 0; i < MaxPayload && i < plen; i++) begin
            w.can_id          = {body_mem[3], body_mem[2], body_mem[1], body_mem[0]};
            w.data_byte       = body_mem[xcfr_pkg::IdBytes + i];
            w.byte_index      = i[5:0];
            w.payload_length  = plen[6:0];
            w.last            = (i + 1 == plen);
            w.checksum_errors = 16'(cks_errs);
            w.length_errors   = 16'(len_errs);
            pending_payload_q.push_back(w);
          end
        end
      end
      default: begin
        rx_phase = (b == xcfr_pkg::SyncFirst) ? xcfr_pkg::StHunt2 : xcfr_pkg::StHunt1;
      end
    endcase
  endtask

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int idle_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one byte on the input side and wait until the receiver takes it.
  task automatic push_rx_byte(input logic [7:0] b);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    do @(posedge clk_i); while (!s_axis_tready);
    parse_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [15:0] len);
    push_rx_byte(xcfr_pkg::SyncFirst);
    push_rx_byte(xcfr_pkg::SyncSecond);
    push_rx_byte(len[7:0]);
    push_rx_byte(len[15:8]);
  endtask

  // Full frame with a valid length; the payload is random unless a fill byte is given.
  task automatic send_frame(input logic [31:0] id, input int plen, input bit bad_sum,
                            input bit use_fill, input logic [7:0] fill);
    logic [7:0] body [$];
    logic [7:0] sum;
    for (int k = 0; k < xcfr_pkg::IdBytes; k++) body.push_back(id[8*k +: 8]);
    for (int k = 0; k < plen; k++) body.push_back(use_fill ? fill : 8'($urandom));
    sum = 8'h00;
    foreach (body[k]) sum ^= body[k];
    if (bad_sum) sum ^= 8'($urandom_range(1, 255));
    send_header(16'(plen + xcfr_pkg::IdBytes));
    foreach (body[k]) push_rx_byte(body[k]);
    push_rx_byte(sum);
  endtask

  function automatic logic [15:0] rand_bad_length();
    if ($urandom_range(0, 2) == 0) return 16'($urandom_range(0, BodyMin - 1));
    return 16'($urandom_range(BodyMax + 1, 16'hFFFF));
  endfunction

  function automatic int rand_plen();
    if ($urandom_range(0, 9) == 0) return $urandom_range(9, 16);
    return $urandom_range(1, 8);
  endfunction

  task automatic test_directed();
    // Smallest frame, identifier all ones and payload all zeros.
    send_frame(32'hFFFF_FFFF, 1, 1'b0, 1'b1, 8'h00);
    // A second 0xAA after the first one drops back to hunting; the 0x55 is then ignored.
    push_rx_byte(xcfr_pkg::SyncFirst);
    push_rx_byte(xcfr_pkg::SyncFirst);
    push_rx_byte(xcfr_pkg::SyncSecond);
    // Lengths just below and just above the legal range, and a bad high byte.
    send_header(16'(BodyMin - 1));
    send_header(16'(BodyMax + 1));
    send_header({8'hFF, 8'(BodyMin)});
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) push_rx_byte($urandom_range(0, 1) ? xcfr_pkg::SyncFirst : 8'($urandom));
  endtask

  task automatic test_random_traffic();
    int start;
    int r;
    start = bytes_sent;
    while (bytes_sent - start < RandomItems) begin
      idle_on = ($urandom_range(0, 4) != 0);
      r = $urandom_range(0, 99);
      if (r < 65) send_frame($urandom, rand_plen(), 1'b0, 1'b0, 8'h00);
      else if (r < 75) send_frame($urandom, rand_plen(), 1'b1, 1'b0, 8'h00);
      else if (r < 85) send_header(rand_bad_length());
      else send_noise();
    end
    idle_on = 1'b1;
  endtask

  // The sink stalls for a long stretch while a full-size frame and another one are offered,
  // so the buffered payload backs up into the input.
  task automatic test_backpressure();
    idle_on = 1'b0;
    holds_asked++;
    send_frame($urandom, MaxPayload, 1'b0, 1'b0, 8'h00);
    send_frame($urandom, 1, 1'b0, 1'b0, 8'h00);
    idle_on = 1'b1;
  endtask

  // Checksum failures and a bad length each count once; a good frame then reports the totals.
  task automatic test_error_counters();
    repeat (2) send_frame($urandom, 1, 1'b1, 1'b0, 8'h00);
    send_header(rand_bad_length());
    send_frame($urandom, 2, 1'b0, 1'b0, 8'h00);
  endtask

  // Sink side: random ready pattern, plus long hold-offs on request.
  initial begin
    int run;
    run = 0;
    forever begin
      @(negedge clk_i);
      if (holds_done < holds_asked) begin
        m_axis_tready = 1'b0;
        repeat (LongHold - 1) @(negedge clk_i);
        holds_done++;
      end else if (run > 0) begin
        run--;
      end else if (!idle_on || $urandom_range(0, 3) != 0) begin
        m_axis_tready = 1'b1;
        run = $urandom_range(0, 6);
      end else begin
        m_axis_tready = 1'b0;
        run = idle_gap();
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors_seen++;
    end
  endtask

  always @(posedge clk_i) begin
    payload_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_payload_q.size() == 0) begin
        $error("payload word 0x%0h arrived with none expected", m_axis_tdata);
        errors_seen++;
      end else begin
        want = pending_payload_q.pop_front();
        check_field("can_id", want.can_id, m_axis_tdata[31:0]);
        check_field("data_byte", 32'(want.data_byte), 32'(m_axis_tdata[39:32]));
        check_field("byte_index", 32'(want.byte_index), 32'(m_axis_tdata[45:40]));
        check_field("payload_length", 32'(want.payload_length), 32'(m_axis_tdata[52:46]));
        check_field("last", 32'(want.last), 32'(m_axis_tlast));
        check_field("checksum_error_count", 32'(want.checksum_errors),
                    32'(m_axis_tdata[68:53]));
        check_field("length_error_count", 32'(want.length_errors), 32'(m_axis_tdata[84:69]));
        check_field("pad", 32'h0, 32'(m_axis_tdata[87:85]));
      end
    end
  end

  // Watchdog: too many cycles in a row with no word moving on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb_xor_checked_frame_receiver: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_backpressure();
    test_random_traffic();
    test_error_counters();

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_payload_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_payload_q.size() != 0) begin
      $error("%0d payload words still expected at the end", pending_payload_q.size());
      errors_seen++;
    end

    if (errors_seen == 0) begin
      $display("tb_xor_checked_frame_receiver: clean");
    end else begin
      $display("tb_xor_checked_frame_receiver: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/xcfr_pkg.sv
rtl/xcfr_ram.sv
rtl/xcfr_parser.sv
rtl/xcfr_emitter.sv
rtl/xor_checked_frame_receiver.sv
rtl/xcfr_checker.sv
dv/tb_xor_checked_frame_receiver.sv
